// ===== hdl/tgde_pkg.sv =====
package tgde_pkg;

  // fixed field widths of the stream items
  localparam int RC_W    = 6;
  localparam int HEAT_W  = 32;
  localparam int DIM_W   = 7;
  localparam int FRAC_W  = 17;

  // fixed point constants, rates are q1.16
  localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'd65536;
  localparam int                FRAC_SHIFT = 16;
  // neighbour sum shift, the divide by eight folded in
  localparam int                DIFF_SHIFT = 19;

  // lower grid size limit and reset value of the size registers
  localparam logic [DIM_W-1:0] DIM_MIN   = 7'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_DIFF = 2'd2;
  localparam logic [1:0] REG_EVAP = 2'd3;

  // command classes handed from front to back
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_BAD   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [RC_W-1:0]    row;
    logic [RC_W-1:0]    col;
    logic [HEAT_W-1:0]  heat;
  } cmd_t;

endpackage

// ===== hdl/tgde_front.sv =====
module tgde_front #(
  parameter int RCW = 7,
  parameter int CCW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [1:0]           s_tuser,   // opcode
  input  logic [47:0]          s_tdata,   // row[5:0], column[11:6], heat_value[43:12]
  input  logic [RCW-1:0]       eff_rows,
  input  logic [CCW-1:0]       eff_cols,
  output logic                 q_valid,
  output tgde_pkg::cmd_t       q_entry,
  input  logic                 q_pop
);

  tgde_pkg::cmd_t fifo_mem [2];
  tgde_pkg::cmd_t in_cmd;
  logic           addr_bad;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;

  // unpack and classify the incoming beat
  always_comb begin
    in_cmd.row  = s_tdata[5:0];
    in_cmd.col  = s_tdata[11:6];
    in_cmd.heat = s_tdata[43:12];
    addr_bad = (int'(in_cmd.row) >= int'(eff_rows)) || (int'(in_cmd.col) >= int'(eff_cols));
    case (s_tuser)
      tgde_pkg::OP_WRITE: in_cmd.kind = addr_bad ? tgde_pkg::KIND_BAD : tgde_pkg::KIND_WRITE;
      tgde_pkg::OP_READ:  in_cmd.kind = addr_bad ? tgde_pkg::KIND_BAD : tgde_pkg::KIND_READ;
      tgde_pkg::OP_STEP:  in_cmd.kind = tgde_pkg::KIND_STEP;
      default:            in_cmd.kind = tgde_pkg::KIND_BAD;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_entry  = fifo_mem[rd_ptr];

  // two entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= in_cmd;
  end

endmodule

// ===== hdl/tgde_back.sv =====
module tgde_back #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int HEAT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  tgde_pkg::cmd_t                      q_entry,
  output logic                                q_pop,
  input  logic [$clog2(MAX_ROWS+1)-1:0]       eff_rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]       eff_cols,
  input  logic [tgde_pkg::FRAC_W-1:0]         diff_frac,
  input  logic [tgde_pkg::FRAC_W-1:0]         evap_frac,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,   // read_heat[31:0]
  output logic [0:0]                          m_tuser    // status
);

  localparam int RB         = $clog2(MAX_ROWS);
  localparam int CB         = $clog2(MAX_COLS);
  localparam int RCW        = $clog2(MAX_ROWS + 1);
  localparam int CCW        = $clog2(MAX_COLS + 1);
  localparam int GA         = RB + CB;
  localparam int GRID_DEPTH = 1 << GA;
  localparam int HB         = HEAT_BITS;
  localparam int SUM_W      = HB + 3;
  localparam int FW         = tgde_pkg::FRAC_W;
  localparam logic [HB-1:0] HEAT_MAX = '1;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RD_WAIT = 8'b0000_0010,
    ST_LOAD    = 8'b0000_0100,
    ST_TAP     = 8'b0000_1000,
    ST_MUL1    = 8'b0001_0000,
    ST_MIX     = 8'b0010_0000,
    ST_MUL2    = 8'b0100_0000,
    ST_WR      = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    SRC_GRID  = 2'd0,
    SRC_SAVED = 2'd1,
    SRC_CUR   = 2'd2,
    SRC_PREV  = 2'd3
  } src_t;

  // storage
  logic [HB-1:0] grid  [GRID_DEPTH];
  logic [HB-1:0] lb_a  [MAX_COLS];
  logic [HB-1:0] lb_b  [MAX_COLS];
  logic [HB-1:0] saved [MAX_COLS];

  state_t            state;
  logic [RB-1:0]     row_idx;
  logic [CB-1:0]     col_idx;
  logic [CB-1:0]     ld_col;
  logic              ld_wr_v;
  logic [CB-1:0]     ld_wr_col;
  logic [3:0]        tap_cnt;
  src_t              src_d;
  logic              cur_sel;
  logic [SUM_W-1:0]  sum;
  logic [HB-1:0]     old_heat;
  logic [SUM_W+FW-1:0] p_diff;
  logic [HB+FW-1:0]  p_keep;
  logic [HB:0]       mix;
  logic [HB+FW:0]    p_evap;
  logic              out_valid;
  logic              out_load;
  logic [31:0]       out_heat;
  logic              out_status;

  logic [HB-1:0]     g_rdata, a_rdata, b_rdata, s_rdata;
  logic [GA-1:0]     g_raddr, g_waddr;
  logic              g_we;
  logic [HB-1:0]     g_wdata;
  logic [CB-1:0]     lb_raddr;

  logic [RB-1:0]     row_last, row_n, tap_row;
  logic [CB-1:0]     col_last, col_w, col_e, tap_col;
  logic              first_row, last_row, last_col;
  src_t              tap_src;
  logic [HB-1:0]     tap_data, cur_rdata, prev_rdata;
  logic [FW-1:0]     keep_frac, evap_keep;
  logic [HB+1:0]     v_wide;
  logic [HB-1:0]     v_sat;

  // row and column neighbours with wrap
  assign row_last  = RB'(eff_rows - RCW'(1));
  assign col_last  = CB'(eff_cols - CCW'(1));
  assign first_row = (row_idx == '0);
  assign last_row  = (row_idx == row_last);
  assign last_col  = (col_idx == col_last);
  assign row_n     = row_idx + RB'(1);
  assign col_w     = (col_idx == '0) ? col_last : col_idx - CB'(1);
  assign col_e     = last_col ? '0 : col_idx + CB'(1);

  // tap order: north w j e, centre w e, south w j e, then the old centre value
  always_comb begin
    tap_col = col_idx;
    tap_src = SRC_CUR;
    tap_row = row_idx;
    if (tap_cnt inside {4'd0, 4'd3, 4'd5}) tap_col = col_w;
    else if (tap_cnt inside {4'd2, 4'd4, 4'd7}) tap_col = col_e;
    if (tap_cnt inside {4'd0, 4'd1, 4'd2}) begin
      tap_src = last_row ? SRC_SAVED : SRC_GRID;
      tap_row = row_n;
    end else if (tap_cnt inside {4'd5, 4'd6, 4'd7}) begin
      tap_src = first_row ? SRC_GRID : SRC_PREV;
      tap_row = row_last;
    end
  end

  // line buffer roles swap every row
  assign cur_rdata  = cur_sel ? b_rdata : a_rdata;
  assign prev_rdata = cur_sel ? a_rdata : b_rdata;

  always_comb begin
    case (src_d)
      SRC_GRID:  tap_data = g_rdata;
      SRC_SAVED: tap_data = s_rdata;
      SRC_CUR:   tap_data = cur_rdata;
      SRC_PREV:  tap_data = prev_rdata;
      default:   tap_data = g_rdata;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && q_valid && (!out_valid || m_tready);

  // memory addressing
  always_comb begin
    case (state)
      ST_IDLE: g_raddr = {RB'(q_entry.row), CB'(q_entry.col)};
      ST_TAP:  g_raddr = {tap_row, tap_col};
      default: g_raddr = {row_idx, ld_col};
    endcase
    lb_raddr = tap_col;
    if (state == ST_WR) begin
      g_we    = 1'b1;
      g_waddr = {row_idx, col_idx};
      g_wdata = v_sat;
    end else begin
      g_we    = q_pop && (q_entry.kind == tgde_pkg::KIND_WRITE);
      g_waddr = {RB'(q_entry.row), CB'(q_entry.col)};
      g_wdata = HB'(q_entry.heat);
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) grid[g_waddr] <= g_wdata;
    g_rdata <= grid[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_wr_v && !cur_sel) lb_a[ld_wr_col] <= g_rdata;
    a_rdata <= lb_a[lb_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_wr_v && cur_sel) lb_b[ld_wr_col] <= g_rdata;
    b_rdata <= lb_b[lb_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_wr_v && first_row) saved[ld_wr_col] <= g_rdata;
    s_rdata <= saved[lb_raddr];
  end

  // cell arithmetic
  assign keep_frac = tgde_pkg::FRAC_ONE - diff_frac;
  assign evap_keep = tgde_pkg::FRAC_ONE - evap_frac;
  assign v_wide    = (HB+2)'(p_evap >> tgde_pkg::FRAC_SHIFT);
  assign v_sat     = (v_wide[HB+1:HB] != 2'b00) ? HEAT_MAX : v_wide[HB-1:0];

  // result register loads on an immediate reply, read data or the end of a step
  assign out_load = ((state == ST_IDLE) && q_pop && (q_entry.kind != tgde_pkg::KIND_READ)
                     && (q_entry.kind != tgde_pkg::KIND_STEP))
                    || (state == ST_RD_WAIT)
                    || ((state == ST_WR) && last_col && last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ld_wr_v   <= 1'b0;
    end else begin
      ld_wr_v <= (state == ST_LOAD);
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_entry.kind)
              tgde_pkg::KIND_WRITE: begin
                out_heat   <= '0;
                out_status <= 1'b0;
              end
              tgde_pkg::KIND_READ: state <= ST_RD_WAIT;
              tgde_pkg::KIND_STEP: begin
                state   <= ST_LOAD;
                row_idx <= '0;
                ld_col  <= '0;
                cur_sel <= 1'b0;
              end
              default: begin
                out_heat   <= '0;
                out_status <= 1'b1;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          out_heat   <= 32'(g_rdata);
          out_status <= 1'b0;
          state      <= ST_IDLE;
        end
        ST_LOAD: begin
          ld_wr_col <= ld_col;
          if (ld_col == col_last) begin
            state   <= ST_TAP;
            tap_cnt <= '0;
            col_idx <= '0;
            sum     <= '0;
          end else begin
            ld_col <= ld_col + CB'(1);
          end
        end
        ST_TAP: begin
          src_d <= tap_src;
          if (tap_cnt == 4'd9) begin
            old_heat <= tap_data;
            state    <= ST_MUL1;
          end else begin
            if (tap_cnt != 4'd0) sum <= sum + SUM_W'(tap_data);
            tap_cnt <= tap_cnt + 4'd1;
          end
        end
        ST_MUL1: begin
          p_diff <= sum * diff_frac;
          p_keep <= old_heat * keep_frac;
          state  <= ST_MIX;
        end
        ST_MIX: begin
          mix   <= (HB+1)'(p_diff >> tgde_pkg::DIFF_SHIFT)
                 + (HB+1)'(p_keep >> tgde_pkg::FRAC_SHIFT);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          p_evap <= mix * evap_keep;
          state  <= ST_WR;
        end
        ST_WR: begin
          if (last_col) begin
            cur_sel <= ~cur_sel;
            if (last_row) begin
              state      <= ST_IDLE;
              out_heat   <= '0;
              out_status <= 1'b0;
            end else begin
              row_idx <= row_idx + RB'(1);
              ld_col  <= '0;
              state   <= ST_LOAD;
            end
          end else begin
            col_idx <= col_idx + CB'(1);
            tap_cnt <= '0;
            sum     <= '0;
            state   <= ST_TAP;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_heat;
  assign m_tuser  = out_status;

  // checks
  a_pop_out_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!out_valid || m_tready))
    else $error("command taken while result register busy");

  a_rd_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_WAIT) |-> !out_valid)
    else $error("read data arrives with result register busy");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_TAP || state == ST_WR)
      |-> (int'(row_idx) < int'(eff_rows)))
    else $error("step row outside grid");

  a_mix_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL2) |-> !mix[HB])
    else $error("diffusion mix above heat maximum");

  a_load_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && ld_col == col_last) |=> (ld_wr_v && state == ST_TAP))
    else $error("row load did not hand over to cell taps");

endmodule

// ===== hdl/toroidal_grid_diffuse_evaporate_unit.sv =====
// Toroidal heat grid with eight-neighbour diffusion and evaporation.
// Slave stream s_*: one beat per command, tuser carries the opcode
// (write cell, read cell, run one step), tdata the cell address and heat.
// Master stream m_*: exactly one beat per command, tdata the heat read back
// (zero for anything but a good read), tuser set when the command was ignored
// (address outside the rows or columns in use, or an unused opcode).
// cfg_*: register writes (rows, columns, diffusion and evaporation rate),
// always ready, to be used only while no command is in flight.
// A two-entry command queue sits in front of the execution engine, so the
// slave side keeps taking beats while a result waits on a stalled master.
// The engine loads the result register for a write or ignored command as it
// takes the command, and for a read from the registered grid data in ST_RD_WAIT.
// A step walks the grid row by row: each row is first copied into a line
// buffer, then each cell takes nine reads through the grid and line buffer
// ports, three multiply and add stages and one write-back.
// While m_tready is low the result register holds and the engine stops
// taking commands; the queue fills and then s_tready drops.
// Reset returns the registers to 64 rows, 64 columns and zero rates; the grid
// contents are undefined until written, there is no clearing pass.
module toroidal_grid_diffuse_evaporate_unit #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int HEAT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,     // opcode
  input  logic [47:0] s_tdata,     // row[5:0], column[11:6], heat_value[43:12]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // read_heat[31:0]
  output logic [0:0]  m_tuser,     // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int FW  = tgde_pkg::FRAC_W;

  logic [tgde_pkg::DIM_W-1:0] rows_in_use;
  logic [tgde_pkg::DIM_W-1:0] cols_in_use;
  logic [FW-1:0]              diffusion_fraction;
  logic [FW-1:0]              evaporation_fraction;

  logic [RCW-1:0]   eff_rows;
  logic [CCW-1:0]   eff_cols;
  logic [FW-1:0]    diff_frac;
  logic [FW-1:0]    evap_frac;
  logic             q_valid;
  logic             q_pop;
  tgde_pkg::cmd_t   q_entry;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use          <= tgde_pkg::DIM_RESET;
      cols_in_use          <= tgde_pkg::DIM_RESET;
      diffusion_fraction   <= '0;
      evaporation_fraction <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgde_pkg::REG_ROWS: rows_in_use          <= cfg_data[tgde_pkg::DIM_W-1:0];
        tgde_pkg::REG_COLS: cols_in_use          <= cfg_data[tgde_pkg::DIM_W-1:0];
        tgde_pkg::REG_DIFF: diffusion_fraction   <= cfg_data;
        tgde_pkg::REG_EVAP: evaporation_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes and rates to what the grid supports
  always_comb begin
    if (rows_in_use < tgde_pkg::DIM_MIN) eff_rows = RCW'(tgde_pkg::DIM_MIN);
    else if (int'(rows_in_use) > MAX_ROWS) eff_rows = RCW'(MAX_ROWS);
    else eff_rows = RCW'(rows_in_use);
    if (cols_in_use < tgde_pkg::DIM_MIN) eff_cols = CCW'(tgde_pkg::DIM_MIN);
    else if (int'(cols_in_use) > MAX_COLS) eff_cols = CCW'(MAX_COLS);
    else eff_cols = CCW'(cols_in_use);
    diff_frac = (diffusion_fraction > tgde_pkg::FRAC_ONE) ? tgde_pkg::FRAC_ONE
                                                          : diffusion_fraction;
    evap_frac = (evaporation_fraction > tgde_pkg::FRAC_ONE) ? tgde_pkg::FRAC_ONE
                                                            : evaporation_fraction;
  end

  tgde_front #(
    .RCW (RCW),
    .CCW (CCW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .eff_rows (eff_rows),
    .eff_cols (eff_cols),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  tgde_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .HEAT_BITS (HEAT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .eff_rows  (eff_rows),
    .eff_cols  (eff_cols),
    .diff_frac (diff_frac),
    .evap_frac (evap_frac),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== tb/toroidal_grid_diffuse_evaporate_unit_tb.sv =====
`timescale 1ns / 1ps

module toroidal_grid_diffuse_evaporate_unit_tb;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic       ST_DONE    = 1'b0;
  localparam logic       ST_IGNORED = 1'b1;
  localparam int         GRID_DIM   = 64;
  localparam logic [31:0] HEAT_TOP  = 32'hFFFF_FFFF;

  typedef struct {
    logic [31:0] heat;
    logic        status;
  } heat_reply_t;

  typedef struct {
    logic        to_3x3;  // reconfigure to a 3 by 3 grid and fill it first
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] heat;
    logic        typed;   // reply typed in below
    logic [31:0] want_heat;
    logic        want_status;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // mirror of the block state
  logic [31:0] heat_cells [GRID_DIM*GRID_DIM];
  bit          cell_written [GRID_DIM*GRID_DIM];
  logic [6:0]  rows_reg, cols_reg;
  logic [16:0] diff_reg, evap_reg;

  heat_reply_t pending_replies[$];
  int  mismatches = 0;
  int  beats_sent = 0, replies_seen = 0, steps_sent = 0, phases_run = 0;
  bit  no_idle = 1'b0;

  directed_row_t directed_rows[15];

  toroidal_grid_diffuse_evaporate_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int rows_eff();
    return (rows_reg < 3) ? 3 : (rows_reg > GRID_DIM) ? GRID_DIM : int'(rows_reg);
  endfunction

  function automatic int cols_eff();
    return (cols_reg < 3) ? 3 : (cols_reg > GRID_DIM) ? GRID_DIM : int'(cols_reg);
  endfunction

  // one diffuse and evaporate pass, computed from a copy of the old grid
  function automatic void diffuse_evaporate();
    logic [31:0] old_cells [GRID_DIM*GRID_DIM];
    logic [63:0] d, e, nsum, mix, v;
    int nr, nc, n, s, w, ea;
    nr = rows_eff();
    nc = cols_eff();
    d = (diff_reg > tgde_pkg::FRAC_ONE) ? 64'(tgde_pkg::FRAC_ONE) : 64'(diff_reg);
    e = (evap_reg > tgde_pkg::FRAC_ONE) ? 64'(tgde_pkg::FRAC_ONE) : 64'(evap_reg);
    old_cells = heat_cells;
    for (int i = 0; i < nr; i++) begin
      n = (i + 1) % nr;
      s = (i + nr - 1) % nr;
      for (int j = 0; j < nc; j++) begin
        w  = (j + nc - 1) % nc;
        ea = (j + 1) % nc;
        nsum = 64'(old_cells[n*GRID_DIM+w]) + 64'(old_cells[n*GRID_DIM+j])
             + 64'(old_cells[n*GRID_DIM+ea]) + 64'(old_cells[i*GRID_DIM+w])
             + 64'(old_cells[i*GRID_DIM+ea]) + 64'(old_cells[s*GRID_DIM+w])
             + 64'(old_cells[s*GRID_DIM+j]) + 64'(old_cells[s*GRID_DIM+ea]);
        mix = ((nsum * d) >> tgde_pkg::DIFF_SHIFT)
            + ((64'(old_cells[i*GRID_DIM+j]) * (64'(tgde_pkg::FRAC_ONE) - d))
               >> tgde_pkg::FRAC_SHIFT);
        v = (mix * (64'(tgde_pkg::FRAC_ONE) - e)) >> tgde_pkg::FRAC_SHIFT;
        heat_cells[i*GRID_DIM+j] = (v > 64'(HEAT_TOP)) ? HEAT_TOP : v[31:0];
      end
    end
  endfunction

  // reply of one command, updating the mirror
  function automatic heat_reply_t grid_reply(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                                             logic [31:0] h);
    heat_reply_t rep;
    rep.heat = '0;
    rep.status = ST_DONE;
    if (op == tgde_pkg::OP_WRITE || op == tgde_pkg::OP_READ) begin
      if (r >= rows_eff() || c >= cols_eff()) rep.status = ST_IGNORED;
      else if (op == tgde_pkg::OP_WRITE) begin
        heat_cells[r*GRID_DIM+c] = h;
        cell_written[r*GRID_DIM+c] = 1'b1;
      end else rep.heat = heat_cells[r*GRID_DIM+c];
    end else if (op == tgde_pkg::OP_STEP) diffuse_evaporate();
    else rep.status = ST_IGNORED;
    return rep;
  endfunction

  // one command beat; typed replies override the prediction
  task automatic send_cmd(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic [31:0] h,
                          bit typed = 0, logic [31:0] th = '0, logic ts = 1'b0);
    heat_reply_t rep;
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, h, c, r};
    do @(posedge clk); while (!s_tready);
    rep = grid_reply(op, r, c, h);
    if (typed) begin
      rep.heat = th;
      rep.status = ts;
    end
    pending_replies.push_back(rep);
    beats_sent++;
    if (op == tgde_pkg::OP_STEP) steps_sent++;
  endtask

  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_valid stays high across back to back writes, set_grid drops it
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tgde_pkg::REG_ROWS: rows_reg = val[6:0];
      tgde_pkg::REG_COLS: cols_reg = val[6:0];
      tgde_pkg::REG_DIFF: diff_reg = val;
      tgde_pkg::REG_EVAP: evap_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [6:0] nr, logic [6:0] nc, logic [16:0] d, logic [16:0] e);
    drain_replies();
    write_reg(tgde_pkg::REG_ROWS, 17'(nr));
    write_reg(tgde_pkg::REG_COLS, 17'(nc));
    write_reg(tgde_pkg::REG_DIFF, d);
    write_reg(tgde_pkg::REG_EVAP, e);
    cfg_valid <= 1'b0;
    @(posedge clk);
    phases_run++;
  endtask

  function automatic logic [31:0] rand_heat();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return HEAT_TOP;
      2: return 32'($urandom_range(0, 32'h0004_0000));
      default: return $urandom();
    endcase
  endfunction

  // write every cell in use that has never been written
  task automatic fill_unwritten();
    for (int i = 0; i < rows_eff(); i++)
      for (int j = 0; j < cols_eff(); j++)
        if (!cell_written[i*GRID_DIM+j])
          send_cmd(tgde_pkg::OP_WRITE, 6'(i), 6'(j), rand_heat());
  endtask

  task automatic random_cmds(int count, bit allow_steps);
    int pick, nr, nc;
    logic [5:0] r, c;
    for (int k = 0; k < count; k++) begin
      nr = rows_eff();
      nc = cols_eff();
      no_idle = (k >= count / 2) && (k < count / 2 + 40);
      pick = $urandom_range(0, 99);
      r = 6'($urandom_range(0, nr - 1));
      c = 6'($urandom_range(0, nc - 1));
      if (pick < 42) send_cmd(tgde_pkg::OP_WRITE, r, c, rand_heat());
      else if (pick < 78) send_cmd(tgde_pkg::OP_READ, r, c, $urandom());
      else if (pick < 90 && (nr < GRID_DIM || nc < GRID_DIM)) begin
        // address outside the grid in use
        if (nr < GRID_DIM && (nc == GRID_DIM || $urandom_range(0, 1)))
          r = 6'($urandom_range(nr, GRID_DIM - 1));
        else c = 6'($urandom_range(nc, GRID_DIM - 1));
        send_cmd($urandom_range(0, 1) ? tgde_pkg::OP_READ : tgde_pkg::OP_WRITE, r, c,
                 $urandom());
      end else if (pick < 96) send_cmd(OP_UNUSED, 6'($urandom()), 6'($urandom()), $urandom());
      else if (allow_steps)
        send_cmd(tgde_pkg::OP_STEP, 6'($urandom()), 6'($urandom()), $urandom());
      else send_cmd(tgde_pkg::OP_READ, r, c, '0);
    end
    no_idle = 1'b0;
  endtask

  // result checking
  always @(posedge clk) begin
    heat_reply_t exp_rep;
    if (!rst && m_tvalid && m_tready) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat heat %h status %b", $time, m_tdata, m_tuser);
      end else begin
        exp_rep = pending_replies.pop_front();
        if (m_tdata !== exp_rep.heat) begin
          mismatches++;
          $display("%0t: read_heat expected %h actual %h", $time, exp_rep.heat, m_tdata);
        end
        if (m_tuser[0] !== exp_rep.status) begin
          mismatches++;
          $display("%0t: status expected %b actual %b", $time, exp_rep.status, m_tuser);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  initial begin
    #36_000_000;
    $display("toroidal_grid_diffuse_evaporate_unit_tb: done, errors");
    $finish;
  end

  initial begin
    int waited;
    // to_3x3, op, row, col, heat, typed, heat, status
    directed_rows = '{
      '{0, tgde_pkg::OP_WRITE,  0,  0, HEAT_TOP,     1, 0,        ST_DONE},
      '{0, tgde_pkg::OP_READ,   0,  0, 0,            1, HEAT_TOP, ST_DONE},
      '{0, tgde_pkg::OP_WRITE, 63, 63, 0,            1, 0,        ST_DONE},
      '{0, tgde_pkg::OP_READ,  63, 63, HEAT_TOP,     1, 0,        ST_DONE},
      '{0, OP_UNUSED,          63, 63, HEAT_TOP,     1, 0,        ST_IGNORED},
      '{0, tgde_pkg::OP_WRITE,  0, 63, 32'h12345678, 0, 0,        ST_DONE},
      '{0, tgde_pkg::OP_READ,   0, 63, 0,            0, 0,        ST_DONE},
      '{1, tgde_pkg::OP_READ,   3,  0, 0,            1, 0,        ST_IGNORED},
      '{0, tgde_pkg::OP_WRITE,  0,  3, HEAT_TOP,     1, 0,        ST_IGNORED},
      '{0, tgde_pkg::OP_READ,  63, 63, 0,            1, 0,        ST_IGNORED},
      '{0, tgde_pkg::OP_WRITE,  1,  1, HEAT_TOP,     0, 0,        ST_DONE},
      '{0, tgde_pkg::OP_STEP,   0,  0, 0,            1, 0,        ST_DONE},
      '{0, tgde_pkg::OP_READ,   1,  1, 0,            0, 0,        ST_DONE},
      '{0, tgde_pkg::OP_READ,   0,  2, 0,            0, 0,        ST_DONE},
      '{0, tgde_pkg::OP_STEP,  63, 63, HEAT_TOP,     0, 0,        ST_DONE}
    };
    rows_reg = tgde_pkg::DIM_RESET;
    cols_reg = tgde_pkg::DIM_RESET;
    diff_reg = '0;
    evap_reg = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].to_3x3) begin
        set_grid(7'd3, 7'd3, 17'h10000, 17'h0);
        fill_unwritten();
      end
      send_cmd(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
               directed_rows[i].heat, directed_rows[i].typed,
               directed_rows[i].want_heat, directed_rows[i].want_status);
    end

    // random phases over several grid sizes and rates
    set_grid(7'd2, 7'd1, 17'h1FFFF, 17'h1FFFF);
    random_cmds(90, 1);
    set_grid(7'd5, 7'd7, 17'h08000, 17'h01000);
    fill_unwritten();
    random_cmds(100, 1);
    set_grid(7'd127, 7'd3, 17'h0AAAA, 17'h15555);
    fill_unwritten();
    random_cmds(100, 1);
    set_grid(7'd3, 7'd100, 17'h01234, 17'h0);
    fill_unwritten();
    random_cmds(100, 1);
    set_grid(7'd8, 7'd6, 17'($urandom_range(0, 17'h1FFFF)), 17'($urandom_range(0, 17'h10000)));
    fill_unwritten();
    random_cmds(100, 1);
    set_grid(7'd64, 7'd4, 17'h04000, 17'h00800);
    fill_unwritten();
    send_cmd(tgde_pkg::OP_STEP, 6'd0, 6'd0, '0);
    random_cmds(100, 0);
    set_grid(7'd4, 7'd4, 17'h0, 17'h10000);
    random_cmds(90, 1);
    set_grid(7'd6, 7'd9, 17'($urandom_range(0, 17'h10000)), 17'($urandom_range(0, 17'h1FFFF)));
    fill_unwritten();
    random_cmds(100, 1);

    // wait for the last replies
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_replies.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, pending_replies.size());
    end
    $display("covered %0d commands, %0d grid steps, %0d grid settings, %0d replies checked",
             beats_sent, steps_sent, phases_run, replies_seen);
    if (mismatches == 0) begin
      $display("toroidal_grid_diffuse_evaporate_unit_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("toroidal_grid_diffuse_evaporate_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tgde_pkg.sv
hdl/tgde_front.sv
hdl/tgde_back.sv
hdl/toroidal_grid_diffuse_evaporate_unit.sv
tb/toroidal_grid_diffuse_evaporate_unit_tb.sv
